>>> rtl/etfi_pkg.sv
// shared types and constants for the escape-time fractal iterator
package etfi_pkg;

  localparam int COORD_W         = 32;  // Q4.28 coordinates and constants
  localparam int ZW              = 40;  // Q12.28 iterate
  localparam int FRAC_W          = 28;
  localparam int MUL_W           = 34;  // shifted product width
  localparam int LIMIT_W         = 12;
  localparam int COUNT_OUT_W     = 12;
  localparam int COUNT_WIDTH_DEF = 12;
  localparam int QUEUE_DEPTH_DEF = 2;

  // fractal modes; the unused code runs as mandelbrot
  localparam logic [1:0] MODE_JULIA = 2'd1;
  localparam logic [1:0] MODE_CUBIC = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_JCR   = 2'd2;
  localparam logic [1:0] REG_JCI   = 2'd3;

  // 2.0 in Q12.28 and 4.0 in the width of the squared-radius sum
  localparam logic signed [ZW-1:0]  TWO_Z     = 40'sh0020000000;
  localparam logic signed [ZW-1:0]  NEG_TWO_Z = -40'sh0020000000;
  localparam logic signed [MUL_W:0] FOUR_SQ   = 35'sh040000000;

  // one classified point waiting for the iteration engine
  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] cr;
    logic [COORD_W-1:0] ci;
    logic               cubic;
  } job_t;

endpackage

>>> rtl/escape_time_fractal_iterator_top.sv
// top level of the escape-time fractal iterator: register port, input side, queue and engine
//
// Each point on the input stream yields one result: the number of iterations of
// z^2+c (mandelbrot, julia) or z^3+c (cubic) run while |z|^2 <= 4 and below the
// configured limit, plus a flag set when the point escaped before the limit.
// All iteration goes through one shared 32x32 multiplier that a sequencer steps
// through the products of each iteration, with more steps per iteration for the
// cubic map than for the quadratic maps. Points are taken in through a short queue
// while the engine works and while a finished result waits on the output. The user
// must see that registers are written only while no point is in flight; the block
// itself does not enforce it. The limit is clamped to 2^COUNT_WIDTH-1.
module escape_time_fractal_iterator_top #(
  parameter int COUNT_WIDTH = etfi_pkg::COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = etfi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  // points
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] point_real, [63:32] point_imag
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [11:0] iteration_count, [15:12] zero
  output logic        out_tuser   // [0] escaped
);

  localparam int CO = etfi_pkg::COORD_W;
  localparam int LW = etfi_pkg::LIMIT_W;
  localparam int OW = etfi_pkg::COUNT_OUT_W;

  logic [1:0]    mode_r;
  logic [LW-1:0] limit_r;
  logic [CO-1:0] jcr_r;
  logic [CO-1:0] jci_r;
  logic          cfg_wr;
  logic [1:0]    reg_idx;

  etfi_pkg::job_t wr_job, rd_job;
  logic           push, pop, q_full, q_empty;
  logic [OW-1:0]  count_w;
  logic           escaped_w;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      limit_r <= LW'(100);
      jcr_r   <= '0;
      jci_r   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        etfi_pkg::REG_MODE:  mode_r  <= cfg_pwdata[1:0];
        etfi_pkg::REG_LIMIT: limit_r <= cfg_pwdata[LW-1:0];
        etfi_pkg::REG_JCR:   jcr_r   <= cfg_pwdata;
        etfi_pkg::REG_JCI:   jci_r   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      etfi_pkg::REG_MODE:  cfg_prdata = 32'(mode_r);
      etfi_pkg::REG_LIMIT: cfg_prdata = 32'(limit_r);
      etfi_pkg::REG_JCR:   cfg_prdata = jcr_r;
      etfi_pkg::REG_JCI:   cfg_prdata = jci_r;
      default:             cfg_prdata = '0;
    endcase
  end

  etfi_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .mode      (mode_r),
    .jcr       (jcr_r),
    .jci       (jci_r),
    .q_full    (q_full),
    .push      (push),
    .job       (wr_job)
  );

  etfi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  etfi_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_job       (rd_job),
    .q_pop       (pop),
    .limit_cfg   (limit_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_count   (count_w),
    .out_escaped (escaped_w)
  );

  assign out_tdata = 16'(count_w);
  assign out_tuser = escaped_w;

endmodule

>>> rtl/etfi_front.sv
// input side: accepts points and turns them into start value, constant and map kind
module etfi_front (
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [2*etfi_pkg::COORD_W-1:0]  in_tdata,  // point_real, point_imag
  input  logic [1:0]                      mode,
  input  logic [etfi_pkg::COORD_W-1:0]    jcr,
  input  logic [etfi_pkg::COORD_W-1:0]    jci,
  input  logic                            q_full,
  output logic                            push,
  output etfi_pkg::job_t                  job
);

  localparam int CW = etfi_pkg::COORD_W;

  logic [CW-1:0] pr;
  logic [CW-1:0] pi;
  logic          julia;

  assign pr    = in_tdata[CW-1:0];
  assign pi    = in_tdata[2*CW-1:CW];
  assign julia = (mode == etfi_pkg::MODE_JULIA);

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  // julia starts at the point and adds the constant, the others start at zero
  always_comb begin
    job.x0    = julia ? pr : '0;
    job.y0    = julia ? pi : '0;
    job.cr    = julia ? jcr : pr;
    job.ci    = julia ? jci : pi;
    job.cubic = (mode == etfi_pkg::MODE_CUBIC);
  end

endmodule

>>> rtl/etfi_queue.sv
// small register queue between the input side and the iteration engine
module etfi_queue #(
  parameter int DEPTH = etfi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  etfi_pkg::job_t wr_job,
  input  logic           pop,
  output etfi_pkg::job_t rd_job,
  output logic           full,
  output logic           empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  etfi_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [FW-1:0]  fill_r;

  assign full   = (fill_r == FW'(DEPTH));
  assign empty  = (fill_r == '0);
  assign rd_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

>>> rtl/etfi_engine.sv
// iteration engine: one shared 32x32 multiplier stepped by a small sequencer
module etfi_engine #(
  parameter int COUNT_WIDTH = etfi_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  input  etfi_pkg::job_t                      q_job,
  output logic                                q_pop,
  input  logic [etfi_pkg::LIMIT_W-1:0]        limit_cfg,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [etfi_pkg::COUNT_OUT_W-1:0]    out_count,
  output logic                                out_escaped
);

  localparam int ZW = etfi_pkg::ZW;
  localparam int MW = etfi_pkg::MUL_W;
  localparam int FW = etfi_pkg::FRAC_W;
  localparam int CO = etfi_pkg::COORD_W;
  localparam int LW = (COUNT_WIDTH > etfi_pkg::LIMIT_W) ? COUNT_WIDTH : etfi_pkg::LIMIT_W;

  typedef enum logic [1:0] {ST_IDLE, ST_ITER, ST_DONE} state_t;

  state_t                  state_r;
  logic [2:0]              step_r;
  logic [COUNT_WIDTH-1:0]  cnt_r;
  logic                    esc_r;
  logic                    out_valid_r;
  logic [etfi_pkg::COUNT_OUT_W-1:0] out_cnt_r;
  logic                    out_esc_r;

  logic [COUNT_WIDTH-1:0]  lim_r;
  logic                    cubic_r;
  logic signed [ZW-1:0]    x_r, y_r;
  logic signed [CO-1:0]    cr_r, ci_r;
  logic signed [MW-1:0]    x2_r, y2_r, t1_r, t2_r, t3_r;
  logic signed [2*CO-1:0]  p_r;

  logic [LW-1:0]           lim_ext, cmax_ext, lim_w, cnt_ext;
  logic [COUNT_WIDTH-1:0]  lim_clamped;
  logic signed [CO-1:0]    mul_a, mul_b;
  logic signed [2*CO-1:0]  prod_full;
  logic signed [MW-1:0]    prod_sh;
  logic signed [MW:0]      sq;
  logic signed [ZW-1:0]    xn, yn;
  logic                    out_range, at_limit, last_step, out_load;

  // limit clamped to what the counter can hold
  assign lim_ext     = LW'(limit_cfg);
  assign cmax_ext    = LW'({COUNT_WIDTH{1'b1}});
  assign lim_w       = (lim_ext < cmax_ext) ? lim_ext : cmax_ext;
  assign lim_clamped = lim_w[COUNT_WIDTH-1:0];

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign at_limit  = (cnt_r == lim_r);
  assign out_range = (x_r > etfi_pkg::TWO_Z) || (x_r < etfi_pkg::NEG_TWO_Z) ||
                     (y_r > etfi_pkg::TWO_Z) || (y_r < etfi_pkg::NEG_TWO_Z);
  assign last_step = cubic_r ? (step_r == 3'd6) : (step_r == 3'd3);

  // operand schedule; x and y fit 32 bits once the range check has passed
  always_comb begin
    case (step_r)
      3'd0: begin
        mul_a = x_r[CO-1:0];
        mul_b = x_r[CO-1:0];
      end
      3'd1: begin
        mul_a = y_r[CO-1:0];
        mul_b = y_r[CO-1:0];
      end
      3'd2: begin
        mul_a = cubic_r ? x2_r[CO-1:0] : x_r[CO-1:0];
        mul_b = cubic_r ? x_r[CO-1:0] : y_r[CO-1:0];
      end
      3'd3: begin
        mul_a = x_r[CO-1:0];
        mul_b = y2_r[CO-1:0];
      end
      3'd4: begin
        mul_a = x2_r[CO-1:0];
        mul_b = y_r[CO-1:0];
      end
      3'd5: begin
        mul_a = y2_r[CO-1:0];
        mul_b = y_r[CO-1:0];
      end
      default: begin
        mul_a = x_r[CO-1:0];
        mul_b = x_r[CO-1:0];
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;
  // arithmetic shift of the registered product gives the floor
  assign prod_sh   = p_r[MW+FW-1:FW];
  assign sq        = (MW+1)'(x2_r) + (MW+1)'(prod_sh);

  always_comb begin
    if (cubic_r) begin
      xn = ZW'(t1_r) - ((ZW'(t2_r) <<< 1) + ZW'(t2_r)) + ZW'(cr_r);
      yn = (ZW'(t3_r) <<< 1) + ZW'(t3_r) - ZW'(prod_sh) + ZW'(ci_r);
    end else begin
      xn = ZW'(x2_r) - ZW'(y2_r) + ZW'(cr_r);
      yn = (ZW'(prod_sh) <<< 1) + ZW'(ci_r);
    end
  end

  assign cnt_ext = LW'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      esc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            state_r <= ST_ITER;
            step_r  <= '0;
            cnt_r   <= '0;
          end
        end
        ST_ITER: begin
          if (step_r == 3'd0 && at_limit) begin
            esc_r   <= 1'b0;
            state_r <= ST_DONE;
          end else if (step_r == 3'd0 && out_range) begin
            esc_r   <= 1'b1;
            state_r <= ST_DONE;
          end else if (step_r == 3'd2 && sq > etfi_pkg::FOUR_SQ) begin
            esc_r   <= 1'b1;
            state_r <= ST_DONE;
          end else if (last_step) begin
            step_r <= '0;
            cnt_r  <= cnt_r + 1'b1;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= prod_full;
    if (out_load) begin
      out_cnt_r <= cnt_ext[etfi_pkg::COUNT_OUT_W-1:0];
      out_esc_r <= esc_r;
    end
    if (q_pop) begin
      x_r     <= ZW'($signed(q_job.x0));
      y_r     <= ZW'($signed(q_job.y0));
      cr_r    <= $signed(q_job.cr);
      ci_r    <= $signed(q_job.ci);
      cubic_r <= q_job.cubic;
      lim_r   <= lim_clamped;
    end else if (state_r == ST_ITER) begin
      case (step_r)
        3'd1: x2_r <= prod_sh;
        3'd2: y2_r <= prod_sh;
        3'd3: t1_r <= prod_sh;
        3'd4: t2_r <= prod_sh;
        3'd5: t3_r <= prod_sh;
        default: ;
      endcase
      if (last_step) begin
        x_r <= xn;
        y_r <= yn;
      end
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_count   = out_cnt_r;
  assign out_escaped = out_esc_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ITER) |-> (cnt_r <= lim_r))
    else $error("iteration count passed the limit");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ITER && $past(state_r) == ST_ITER) |->
      (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + 1))
    else $error("iteration count moved by more than one");

  a_quad_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ITER && !cubic_r) |-> (step_r <= 3'd3))
    else $error("quadratic map ran into cubic steps");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_tvalid && $past(state_r) == ST_DONE && state_r == ST_IDLE))
    else $error("finished result not presented");
`endif

endmodule

>>> dv/tb.sv
// self-checking testbench for the escape-time fractal iterator
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] MODE_MANDEL = 2'd0;
  localparam logic [1:0] MODE_SPARE  = 2'd3;  // unused code, runs as mandelbrot
  localparam longint Q_TWO  = longint'(2) << etfi_pkg::FRAC_W;
  localparam longint Q_FOUR = longint'(4) << etfi_pkg::FRAC_W;

  typedef struct packed {
    logic [etfi_pkg::COUNT_OUT_W-1:0] iter_count;
    logic                             escaped;
  } result_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata    = '0;   // [31:0] point_real, [63:32] point_imag
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;          // [11:0] iteration_count, [15:12] zero
  logic        out_tuser;          // [0] escaped

  escape_time_fractal_iterator_top dut (
    .clk, .rst_n,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  // register copies for the predictor
  logic [1:0]  mode_now  = MODE_MANDEL;
  logic [11:0] limit_now = 12'd100;
  logic [31:0] jr_now    = '0;
  logic [31:0] ji_now    = '0;

  logic [63:0] pending_points[$];
  result_t     expected_counts[$];

  int mismatches   = 0;
  int results_seen = 0;
  int escaped_seen = 0;
  int settings_run = 0;
  int burst_left   = 0;
  int gap_left     = 0;
  int pat_age      = 0;
  logic [15:0] ready_pat = 16'hffff;
  result_t     want;
  logic        fired;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 20) $display("tb: mismatch at %0t: %s", $time, what);
  endtask

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> etfi_pkg::FRAC_W;
  endfunction

  // iteration count and escape flag for one point under the current registers
  function automatic result_t escape_time(input logic [31:0] re, input logic [31:0] im);
    longint x, y, cr, ci, x2, y2, xn, yn;
    int unsigned n;
    result_t r;
    x  = 0;
    y  = 0;
    cr = longint'($signed(re));
    ci = longint'($signed(im));
    if (mode_now == etfi_pkg::MODE_JULIA) begin
      x  = cr;
      y  = ci;
      cr = longint'($signed(jr_now));
      ci = longint'($signed(ji_now));
    end
    n = 0;
    while (n < limit_now) begin
      if (x > Q_TWO || x < -Q_TWO || y > Q_TWO || y < -Q_TWO) break;
      x2 = qmul(x, x);
      y2 = qmul(y, y);
      if (x2 + y2 > Q_FOUR) break;
      if (mode_now == etfi_pkg::MODE_CUBIC) begin
        xn = qmul(x2, x) - 3 * qmul(x, y2) + cr;
        yn = 3 * qmul(x2, y) - qmul(y2, y) + ci;
      end else begin
        xn = x2 - y2 + cr;
        yn = 2 * qmul(x, y) + ci;
      end
      x = xn;
      y = yn;
      n++;
    end
    r.iter_count = n[11:0];
    r.escaped    = (n < limit_now);
    return r;
  endfunction

  function automatic logic [31:0] to_q(input real r);
    return int'(r * 268435456.0);
  endfunction

  function automatic logic [31:0] pick_coord(input int unsigned span);
    int v;
    v = int'($urandom_range(2 * span, 0)) - int'(span);
    return v;
  endfunction

  task automatic queue_point(input logic [31:0] re, input logic [31:0] im);
    pending_points.push_back({im, re});
  endtask

  // mostly points near the set, some anywhere in the Q4.28 range
  task automatic queue_random_point();
    int unsigned sel;
    sel = $urandom_range(9, 0);
    if (sel == 0) queue_point($urandom, $urandom);
    else if (sel == 1) queue_point($urandom, pick_coord(to_q(2.2)));
    else if (sel == 2) queue_point(pick_coord(to_q(2.2)), $urandom);
    else queue_point(pick_coord(to_q(2.2)), pick_coord(to_q(2.2)));
  endtask

  // sampled away from the rising edge so driver and monitor updates have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_points.size() != 0 || in_tvalid || expected_counts.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      etfi_pkg::REG_MODE:  mode_now  = val[1:0];
      etfi_pkg::REG_LIMIT: limit_now = val[11:0];
      etfi_pkg::REG_JCR:   jr_now    = val;
      etfi_pkg::REG_JCI:   ji_now    = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [1:0] mode, input logic [11:0] limit,
                               input logic [31:0] jr, input logic [31:0] ji);
    wait_idle();
    write_reg(etfi_pkg::REG_MODE, {30'd0, mode});
    write_reg(etfi_pkg::REG_LIMIT, {20'd0, limit});
    write_reg(etfi_pkg::REG_JCR, jr);
    write_reg(etfi_pkg::REG_JCI, ji);
    settings_run++;
  endtask

  // stimulus
  initial begin
    logic [1:0]  mode;
    logic [11:0] limit;
    logic [31:0] jr, ji;
    int          n_items;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    settings_run = 1;

    // reset registers: mandelbrot, limit 100
    queue_point(32'd0, 32'd0);
    queue_point(32'h7fffffff, 32'h7fffffff);
    queue_point(32'h80000000, 32'h80000000);
    queue_point(32'h80000000, 32'd0);
    queue_point(32'd0, 32'h7fffffff);
    queue_point(to_q(-2.0), 32'd0);
    queue_point(to_q(2.0), 32'd0);
    queue_point(to_q(0.25), 32'd0);
    queue_point(to_q(-0.75), to_q(0.1));
    queue_point(32'd0, to_q(1.0));
    queue_point(to_q(-1.0), 32'd0);
    queue_point(32'd1, 32'hffffffff);
    queue_point(to_q(0.5), to_q(0.5));

    // zero limit: nothing iterates
    apply_setting(MODE_SPARE, 12'd0, 32'd0, 32'd0);
    queue_point(32'd0, 32'd0);
    queue_point(32'h7fffffff, 32'h80000000);

    // the spare mode code behaves as mandelbrot
    apply_setting(MODE_SPARE, 12'd100, 32'd0, 32'd0);
    queue_point(to_q(-0.75), to_q(0.1));
    queue_point(to_q(0.3), to_q(0.6));

    // limit of one with extreme julia constants; escape on the last allowed pass
    apply_setting(etfi_pkg::MODE_JULIA, 12'd1, 32'h7fffffff, 32'h80000000);
    queue_point(32'd0, 32'd0);
    queue_point(to_q(3.0), 32'd0);
    queue_point(to_q(1.0), to_q(1.0));

    apply_setting(etfi_pkg::MODE_CUBIC, 12'd100, 32'h7fffffff, 32'h80000000);
    queue_point(32'd0, 32'd0);
    queue_point(to_q(0.5), to_q(0.5));
    queue_point(to_q(-0.6), to_q(0.3));
    queue_point(to_q(1.5), 32'd0);

    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0:       mode = MODE_MANDEL;
        1:       mode = etfi_pkg::MODE_JULIA;
        2:       mode = etfi_pkg::MODE_CUBIC;
        default: mode = MODE_SPARE;
      endcase
      limit = (p == 6) ? 12'($urandom_range(12, 1)) : 12'($urandom_range(80, 1));
      if (p % 5 == 0) begin
        jr = $urandom;
        ji = $urandom;
      end else begin
        jr = pick_coord(to_q(1.0));
        ji = pick_coord(to_q(1.0));
      end
      n_items = 103;
      // deep runs at the largest limit, with points mostly inside the set
      if (p == 3 || p == 9) begin
        mode    = (p == 3) ? MODE_MANDEL : etfi_pkg::MODE_CUBIC;
        limit   = 12'd4095;
        n_items = 5;
      end
      apply_setting(mode, limit, jr, ji);
      for (int i = 0; i < n_items; i++) begin
        if (limit == 12'd4095) queue_point(pick_coord(to_q(0.3)), pick_coord(to_q(0.3)));
        else queue_random_point();
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (expected_counts.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_counts.size()));
    $display("tb: %0d points checked over %0d register settings", results_seen, settings_run);
    $display("tb: %0d escaped, %0d stopped at the limit", escaped_seen,
             results_seen - escaped_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // point driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      fired = in_tvalid && in_tready;
      if (fired) expected_counts.push_back(escape_time(in_tdata[31:0], in_tdata[63:32]));
      if (!in_tvalid || fired) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_points.size() != 0) begin
          in_tdata  <= pending_points.pop_front();
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(20, 1);
            gap_left   = $urandom_range(1, 0) ? $urandom_range(12, 1) : 0;
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor; ready follows a rotating pattern that is redrawn now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_counts.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_counts.pop_front();
          if (out_tdata !== {4'd0, want.iter_count})
            report_mismatch($sformatf("iteration_count got %h want %h",
                                      out_tdata, {4'd0, want.iter_count}));
          if (out_tuser !== want.escaped)
            report_mismatch($sformatf("escaped got %b want %b", out_tuser, want.escaped));
          results_seen++;
          if (want.escaped) escaped_seen++;
        end
      end
      ready_pat = {ready_pat[0], ready_pat[15:1]};
      pat_age++;
      if (pat_age == 48) begin
        pat_age   = 0;
        ready_pat = ($urandom_range(2, 0) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
      end
      out_tready <= ready_pat[0];
    end
  end

endmodule
